// File: rtl/core/bfmg_pkg.sv
// Shared constants and codes for the box filter mipmap generator.
package bfmg_pkg;

  localparam int STORE_BYTES_DEF = 65536;
  localparam int MAX_SIDE_DEF    = 64;
  localparam int MAX_SLICES_DEF  = 8;

  localparam int SIDE_W  = 7;
  localparam int DEPTH_W = 4;
  localparam int CC_W    = 3;
  localparam int TOTAL_W = 24;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_GEN,
    KIND_READ,
    KIND_NONE
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_TOO_LARGE
  } status_t;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_DEPTH,
    REG_COMPONENTS
  } reg_index_t;

  function automatic logic [SIDE_W-1:0] halve(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] h;
    h = v >> 1;
    return (h == '0) ? SIDE_W'(1) : h;
  endfunction

endpackage

// File: rtl/core/bfmg_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module bfmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/box_filter_mipmap_generator_top.sv
// Box filter mipmap generator: byte store, configuration port and chain sequencer.
// Load and read words may be issued every cycle while busy is low; the result strobe is
// registered and rises in the cycle after the word is accepted. A generate word holds
// busy high while one shared multiply-add unit sizes the chain level by level, then
// builds each output byte from its eight neighbors. Synchronous reset clears the
// configuration to its defaults and the sequencer to idle; the store is not cleared.
module box_filter_mipmap_generator_top
  import bfmg_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF,
  parameter int MAX_SIDE    = MAX_SIDE_DEF,
  parameter int MAX_SLICES  = MAX_SLICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [15:0] byte_address,
  input  logic [7:0]  byte_value,
  output logic        done,
  output logic [7:0]  read_value,
  output logic [1:0]  status,
  output logic [16:0] chain_bytes
);

  localparam int AW = $clog2(STORE_BYTES);

  typedef enum logic [4:0] {
    S_IDLE, S_SZ1, S_SZ2, S_SZ3, S_SZ4,
    S_L1, S_L2, S_L3, S_L4,
    S_T1, S_T2, S_T3, S_T4, S_T5, S_WR, S_DONE
  } state_t;

  state_t state;

  logic [SIDE_W-1:0]  image_width, image_height;
  logic [DEPTH_W-1:0] image_depth;
  logic [CC_W-1:0]    component_count;

  logic [SIDE_W-1:0]  tw, th, td, pw, ph, pd, lw, lh, ld;
  logic [SIDE_W-1:0]  cw, ch, cd;
  logic [CC_W-1:0]    cc, cc_eff;
  logic [TOTAL_W-1:0] total, base, nxt, macr;
  logic [AW-1:0]      p;
  logic [SIDE_W-1:0]  x, y, z;
  logic [1:0]         c_idx;
  logic [2:0]         tap;
  logic [10:0]        sum;
  logic               is_read;
  status_t            status_r;
  logic [16:0]        chain_r;

  logic [TOTAL_W-1:0] mac_a, mac_c;
  logic [SIDE_W-1:0]  mac_b;
  logic [TOTAL_W+SIDE_W-1:0] mac_full;
  logic [SIDE_W-1:0]  x_s, y_s, z_s;

  logic               accept, in_range, cfg_we;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;
  logic               last_c, last_x, last_y, last_z;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign in_range = TOTAL_W'(byte_address) < TOTAL_W'(STORE_BYTES);

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_WIDTH:      prdata = 32'(image_width);
      REG_HEIGHT:     prdata = 32'(image_height);
      REG_DEPTH:      prdata = 32'(image_depth);
      REG_COMPONENTS: prdata = 32'(component_count);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width == '0) cw = SIDE_W'(1);
    else if (32'(image_width) > 32'(MAX_SIDE)) cw = SIDE_W'(MAX_SIDE);
    else cw = image_width;
    if (image_height == '0) ch = SIDE_W'(1);
    else if (32'(image_height) > 32'(MAX_SIDE)) ch = SIDE_W'(MAX_SIDE);
    else ch = image_height;
    if (image_depth == '0) cd = SIDE_W'(1);
    else if (32'(image_depth) > 32'(MAX_SLICES)) cd = SIDE_W'(MAX_SLICES);
    else cd = SIDE_W'(image_depth);
    if (component_count == '0) cc_eff = CC_W'(1);
    else if (component_count > CC_W'(4)) cc_eff = CC_W'(4);
    else cc_eff = component_count;
  end

  assign x_s = (pw == SIDE_W'(1)) ? '0 : SIDE_W'({x[SIDE_W-2:0], tap[0]});
  assign y_s = (ph == SIDE_W'(1)) ? '0 : SIDE_W'({y[SIDE_W-2:0], tap[1]});
  assign z_s = (pd == SIDE_W'(1)) ? '0 : SIDE_W'({z[SIDE_W-2:0], tap[2]});

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    case (state)
      S_SZ1: begin
        mac_a = TOTAL_W'(tw);
        mac_b = th;
      end
      S_SZ2: begin
        mac_a = macr;
        mac_b = td;
      end
      S_SZ3: begin
        mac_a = macr;
        mac_b = SIDE_W'(cc);
        mac_c = total;
      end
      S_L1: begin
        mac_a = TOTAL_W'(pw);
        mac_b = ph;
      end
      S_L2: begin
        mac_a = macr;
        mac_b = pd;
      end
      S_L3: begin
        mac_a = macr;
        mac_b = SIDE_W'(cc);
        mac_c = base;
      end
      S_T1: begin
        mac_a = TOTAL_W'(z_s);
        mac_b = ph;
        mac_c = TOTAL_W'(y_s);
      end
      S_T2: begin
        mac_a = macr;
        mac_b = pw;
        mac_c = TOTAL_W'(x_s);
      end
      S_T3: begin
        mac_a = macr;
        mac_b = SIDE_W'(cc);
        mac_c = base + TOTAL_W'(c_idx);
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  assign mac_full = mac_a * mac_b + mac_c;

  assign last_c = ({1'b0, c_idx} == cc - CC_W'(1));
  assign last_x = (x == lw - SIDE_W'(1));
  assign last_y = (y == lh - SIDE_W'(1));
  assign last_z = (z == ld - SIDE_W'(1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(byte_address);
    ram_wdata = byte_value;
    ram_raddr = AW'(byte_address);
    case (state)
      S_IDLE: ram_we = accept && (kind_t'(kind) == KIND_LOAD) && in_range;
      S_T4:   ram_raddr = macr[AW-1:0];
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = p;
        ram_wdata = sum[10:3];
      end
      default: ram_we = 1'b0;
    endcase
  end

  bfmg_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= SIDE_W'(1);
      image_height    <= SIDE_W'(1);
      image_depth     <= DEPTH_W'(1);
      component_count <= CC_W'(4);
    end else if (cfg_we) begin
      case (reg_index_t'(paddr[3:2]))
        REG_WIDTH:      image_width     <= pwdata[SIDE_W-1:0];
        REG_HEIGHT:     image_height    <= pwdata[SIDE_W-1:0];
        REG_DEPTH:      image_depth     <= pwdata[DEPTH_W-1:0];
        REG_COMPONENTS: component_count <= pwdata[CC_W-1:0];
        default:        image_width     <= image_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      macr <= mac_full[TOTAL_W-1:0];
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_read  <= 1'b0;
            chain_r  <= '0;
            status_r <= ST_OK;
            case (kind_t'(kind))
              KIND_GEN: begin
                tw    <= cw;
                th    <= ch;
                td    <= cd;
                cc    <= cc_eff;
                total <= '0;
                state <= S_SZ1;
              end
              KIND_LOAD, KIND_READ: begin
                done     <= 1'b1;
                is_read  <= in_range && (kind_t'(kind) == KIND_READ);
                status_r <= in_range ? ST_OK : ST_RANGE;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_SZ1: state <= S_SZ2;
        S_SZ2: state <= S_SZ3;
        S_SZ3: state <= S_SZ4;
        S_SZ4: begin
          total <= macr;
          if (tw > SIDE_W'(1) || th > SIDE_W'(1) || td > SIDE_W'(1)) begin
            tw    <= halve(tw);
            th    <= halve(th);
            td    <= halve(td);
            state <= S_SZ1;
          end else if (macr > TOTAL_W'(STORE_BYTES)) begin
            done     <= 1'b1;
            status_r <= ST_TOO_LARGE;
            state    <= S_IDLE;
          end else begin
            pw   <= cw;
            ph   <= ch;
            pd   <= cd;
            base <= '0;
            if (cw > SIDE_W'(1) || ch > SIDE_W'(1) || cd > SIDE_W'(1)) begin
              state <= S_L1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_L1: state <= S_L2;
        S_L2: state <= S_L3;
        S_L3: state <= S_L4;
        S_L4: begin
          nxt   <= macr;
          p     <= macr[AW-1:0];
          lw    <= halve(pw);
          lh    <= halve(ph);
          ld    <= halve(pd);
          x     <= '0;
          y     <= '0;
          z     <= '0;
          c_idx <= '0;
          tap   <= '0;
          sum   <= '0;
          state <= S_T1;
        end
        S_T1: state <= S_T2;
        S_T2: state <= S_T3;
        S_T3: state <= S_T4;
        S_T4: state <= S_T5;
        S_T5: begin
          sum <= sum + 11'(ram_rdata);
          tap <= tap + 3'd1;
          state <= (tap == 3'd7) ? S_WR : S_T1;
        end
        S_WR: begin
          sum   <= '0;
          p     <= p + AW'(1);
          state <= S_T1;
          if (!last_c) begin
            c_idx <= c_idx + 2'd1;
          end else begin
            c_idx <= '0;
            if (!last_x) begin
              x <= x + SIDE_W'(1);
            end else begin
              x <= '0;
              if (!last_y) begin
                y <= y + SIDE_W'(1);
              end else begin
                y <= '0;
                if (!last_z) begin
                  z <= z + SIDE_W'(1);
                end else begin
                  base <= nxt;
                  pw   <= lw;
                  ph   <= lh;
                  pd   <= ld;
                  if (lw > SIDE_W'(1) || lh > SIDE_W'(1) || ld > SIDE_W'(1)) begin
                    state <= S_L1;
                  end else begin
                    state <= S_DONE;
                  end
                end
              end
            end
          end
        end
        S_DONE: begin
          done     <= 1'b1;
          status_r <= ST_OK;
          chain_r  <= total[16:0];
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign read_value  = is_read ? ram_rdata : 8'd0;
  assign status      = status_r;
  assign chain_bytes = chain_r;

endmodule

// File: dv/tb_box_filter_mipmap_generator_top.sv
// Self-checking testbench for the box filter mipmap generator: loads, reads and chain builds.
module tb_box_filter_mipmap_generator_top;
  import bfmg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE    = 65536;
  localparam int WD_LIMIT = 400000;

  typedef struct packed {
    logic [7:0]  read_value;
    status_t     status;
    logic [16:0] chain_bytes;
  } word_result_t;

  typedef struct {
    kind_t        k;
    logic [15:0]  addr;
    logic [7:0]   val;
    word_result_t res;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = KIND_NONE;
  logic [15:0] byte_address = '0;
  logic [7:0]  byte_value = '0;
  logic        done;
  logic [7:0]  read_value;
  logic [1:0]  status;
  logic [16:0] chain_bytes;

  box_filter_mipmap_generator_top dut (.*);

  always #10 clk = ~clk;

  logic [7:0]   pix_mem [STORE];
  bit           pix_known [STORE];
  int           known_addrs [$];
  logic [6:0]   cfg_width, cfg_height;
  logic [3:0]   cfg_depth;
  logic [2:0]   cfg_comps;
  logic [6:0]   last_dims [3];
  logic [16:0]  last_chain;
  word_result_t pending_words [$];
  int           mismatches = 0;
  int           words_sent = 0;
  int           idle_cycles = 0;
  bit           gaps_on = 1'b1;

  function automatic int clamp_side(int v, int cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  function automatic int half_side(int v);
    return (v >> 1) ? (v >> 1) : 1;
  endfunction

  function automatic longint chain_size(int w, int h, int d, int cc);
    longint total;
    int big;
    big = (w > h) ? w : h;
    big = (d > big) ? d : big;
    total = longint'(w) * h * d * cc;
    while (big > 1) begin
      w = half_side(w);
      h = half_side(h);
      d = half_side(d);
      big >>= 1;
      total += longint'(w) * h * d * cc;
    end
    return total;
  endfunction

  function automatic void store_byte(int a, logic [7:0] v);
    pix_mem[a] = v;
    if (!pix_known[a]) begin
      pix_known[a] = 1'b1;
      known_addrs.push_back(a);
    end
  endfunction

  function automatic status_t build_chain(output logic [16:0] total_out);
    int w, h, d, cc, levels, big, tw, th, td, pw, ph, pd, sum, xs, ys, zs;
    longint total, base, nxt, p;
    w = clamp_side(cfg_width, 64);
    h = clamp_side(cfg_height, 64);
    d = clamp_side(cfg_depth, 8);
    cc = (cfg_comps == 0) ? 1 : ((cfg_comps > 4) ? 4 : cfg_comps);
    big = (w > h) ? w : h;
    big = (d > big) ? d : big;
    levels = 1;
    while (big > 1) begin
      levels++;
      big >>= 1;
    end
    total = 0;
    tw = w; th = h; td = d;
    for (int j = 0; j < levels; j++) begin
      total += longint'(tw) * th * td * cc;
      tw = half_side(tw); th = half_side(th); td = half_side(td);
    end
    total_out = '0;
    if (total > STORE) return ST_TOO_LARGE;
    base = 0;
    for (int j = 1; j < levels; j++) begin
      pw = w; ph = h; pd = d;
      nxt = base + longint'(pw) * ph * pd * cc;
      p = nxt;
      w = half_side(w); h = half_side(h); d = half_side(d);
      for (int z = 0; z < d; z++)
        for (int y = 0; y < h; y++)
          for (int x = 0; x < w; x++)
            for (int c = 0; c < cc; c++) begin
              sum = 0;
              for (int i = 0; i < 8; i++) begin
                xs = (2 * x + (i & 1)) % pw;
                ys = (2 * y + ((i >> 1) & 1)) % ph;
                zs = (2 * z + ((i >> 2) & 1)) % pd;
                sum += pix_mem[int'(base + ((longint'(zs) * ph + ys) * pw + xs) * cc + c)];
              end
              store_byte(int'(p), 8'(sum >> 3));
              p++;
            end
      base = nxt;
    end
    last_dims[0] = 7'(w);
    last_dims[1] = 7'(h);
    last_dims[2] = 7'(d);
    last_chain = 17'(total);
    total_out = 17'(total);
    return ST_OK;
  endfunction

  function automatic word_result_t predict_word(kind_t k, logic [15:0] a, logic [7:0] v);
    word_result_t r;
    logic [16:0] cb;
    r = '{read_value: '0, status: ST_OK, chain_bytes: '0};
    case (k)
      KIND_LOAD: store_byte(a, v);
      KIND_READ: r.read_value = pix_mem[a];
      KIND_GEN: begin
        r.status = build_chain(cb);
        r.chain_bytes = cb;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(kind_t k, logic [15:0] a, logic [7:0] v,
                           bit typed = 1'b0, word_result_t typed_res = '0);
    word_result_t r;
    start <= 1'b1;
    kind <= k;
    byte_address <= a;
    byte_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_word(k, a, v);
    pending_words.push_back(typed ? typed_res : r);
    words_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic reg_write(reg_index_t idx, int value, int width);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(4 * idx);
    pwdata <= ($urandom() << width) | value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_image(int w, int h, int d, int cc);
    wait_idle();
    reg_write(REG_WIDTH, w, 7);
    reg_write(REG_HEIGHT, h, 7);
    reg_write(REG_DEPTH, d, 4);
    reg_write(REG_COMPONENTS, cc, 3);
    cfg_width = 7'(w);
    cfg_height = 7'(h);
    cfg_depth = 4'(d);
    cfg_comps = 3'(cc);
  endtask

  task automatic run_image(int w, int h, int d, int cc, int ops);
    int base_len, pick;
    bit too_big;
    set_image(w, h, d, cc);
    base_len = clamp_side(w, 64) * clamp_side(h, 64) * clamp_side(d, 8)
             * ((cc == 0) ? 1 : ((cc > 4) ? 4 : cc));
    too_big = chain_size(clamp_side(w, 64), clamp_side(h, 64), clamp_side(d, 8),
                         (cc == 0) ? 1 : ((cc > 4) ? 4 : cc)) > STORE;
    if (base_len <= 1024)
      for (int i = 0; i < base_len; i++) send_word(KIND_LOAD, 16'(i), 8'($urandom));
    else
      base_len = 0;
    for (int i = 0; i < ops; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4 || i == ops / 3) begin
        if (base_len != 0 || too_big) send_word(KIND_GEN, 16'($urandom), 8'($urandom));
      end else if (pick < 8)
        send_word(KIND_NONE, 16'($urandom), 8'($urandom));
      else if (pick < 30)
        send_word(KIND_LOAD, 16'($urandom), 8'($urandom));
      else
        send_word(KIND_READ, 16'(known_addrs[$urandom_range(0, known_addrs.size() - 1)]),
                  8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    word_result_t want;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("box_filter_mipmap_generator_top regression: fail");
        $finish;
      end
      if (done) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %0h %0d %0h",
                                         read_value, status, chain_bytes);
        end else begin
          want = pending_words.pop_front();
          if (read_value !== want.read_value || status !== want.status ||
              chain_bytes !== want.chain_bytes) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp rv=%0h st=%0d cb=%0d got rv=%0h st=%0d cb=%0d",
                       want.read_value, want.status, want.chain_bytes,
                       read_value, status, chain_bytes);
          end
        end
      end
    end
  end

  table_row_t opening_rows [11] = '{
    '{KIND_LOAD, 16'h0000, 8'h00, '{8'h00, ST_OK, 17'd0}},
    '{KIND_LOAD, 16'hFFFF, 8'hFF, '{8'h00, ST_OK, 17'd0}},
    '{KIND_LOAD, 16'h0001, 8'hA5, '{8'h00, ST_OK, 17'd0}},
    '{KIND_LOAD, 16'h0002, 8'h5A, '{8'h00, ST_OK, 17'd0}},
    '{KIND_LOAD, 16'h0003, 8'hFF, '{8'h00, ST_OK, 17'd0}},
    '{KIND_READ, 16'hFFFF, 8'h00, '{8'hFF, ST_OK, 17'd0}},
    '{KIND_READ, 16'h0000, 8'hFF, '{8'h00, ST_OK, 17'd0}},
    '{KIND_READ, 16'h0001, 8'h00, '{8'hA5, ST_OK, 17'd0}},
    '{KIND_NONE, 16'hFFFF, 8'hFF, '{8'h00, ST_OK, 17'd0}},
    '{KIND_GEN,  16'h0000, 8'h00, '{8'h00, ST_OK, 17'd4}},
    '{KIND_READ, 16'h0003, 8'h00, '{8'hFF, ST_OK, 17'd0}}
  };

  initial begin
    cfg_width = 7'd1;
    cfg_height = 7'd1;
    cfg_depth = 4'd1;
    cfg_comps = 3'd4;
    last_chain = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (opening_rows[i])
      send_word(opening_rows[i].k, opening_rows[i].addr, opening_rows[i].val,
                1'b1, opening_rows[i].res);
    run_image(64, 64, 8, 4, 20);
    run_image(0, 0, 0, 0, 30);
    run_image(127, 1, 0, 0, 40);
    run_image(1, 127, 1, 1, 40);
    run_image(1, 1, 15, 7, 30);
    run_image(64, 64, 1, 1, 10);
    run_image(3, 5, 2, 4, 40);
    while (words_sent < 1750) begin
      if (words_sent > 1450) gaps_on = 1'b0;
      run_image($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(0, 3),
                $urandom_range(0, 7), $urandom_range(30, 80));
    end
    wait_idle();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("box_filter_mipmap_generator_top regression: pass");
    end else begin
      $display("box_filter_mipmap_generator_top regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bfmg_pkg.sv
rtl/core/bfmg_ram.sv
rtl/core/box_filter_mipmap_generator_top.sv
dv/tb_box_filter_mipmap_generator_top.sv
